>>> hdl/bbhs_pkg.sv
// Shared types and constants for the bitmap bucket hash set.
package bbhs_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned FILL_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned KEY_W = 58;
  localparam int unsigned MAP_W = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BIT_W = 6;
  localparam int unsigned CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  localparam logic [FILL_W-1:0] MAX_FILL_RESET = 10'd768;
  localparam logic [63:0] GOLDEN_MULT = 64'h9E3779B97F4A7C15;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MAP_W-1:0] bitmap;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage

>>> hdl/bitmap_bucket_hash_set.sv
// Top level of the bitmap bucket hash set: sequencer, hash accumulator and probe control.
//
// After reset the block sweeps the 1024-slot store to empty, one slot a cycle, and holds
// busy_o high throughout the sweep. A transaction then hashes the key on the shared
// 32x32 multiplier (three partial products, accumulated one per cycle), forms the home
// slot, reads each probed slot through the registered store read and checks it, and
// then updates the store for an add, with the result strobed on done_o afterwards for a single
// cycle. The receiver cannot stall, so the result must be captured in the
// cycle done_o is high; a new transaction may start in that same cycle.
module bitmap_bucket_hash_set (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          command_i,
  input  logic [bbhs_pkg::VALUE_W-1:0]  value_i,
  input  logic                          cfg_we_i,
  input  logic [bbhs_pkg::FILL_W-1:0]   cfg_wdata_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic                          present_o,
  output logic                          status_o,
  output logic [bbhs_pkg::COUNT_W-1:0]  bucket_count_o
);
  import bbhs_pkg::*;

  state_e state_q, state_d;

  logic [FILL_W-1:0]  max_fill_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [1:0]         hstep_q, hstep_d;
  logic [63:0]        acc_q, acc_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   probe_q, probe_d;
  logic               cmd_q, cmd_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               found_q, found_d;
  logic               free_q, free_d;
  logic               done_q, done_d;
  logic               present_q, present_d;
  logic               status_q, status_d;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [63:0]        addend;
  logic [KEY_W-1:0]   key;
  logic [MAP_W-1:0]   bit_mask;
  logic [IDX_W:0]     home_wide;
  logic               rd_en;
  wr_req_t            wr_req;
  entry_t             rd_data;
  logic               miss_end;
  logic               room;

  bbhs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bbhs_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  assign key      = value_q[VALUE_W-1:BIT_W];
  assign bit_mask = MAP_W'(1) << value_q[BIT_W-1:0];

  // Low 64 bits of key * constant: kl*cl + ((kl*ch + kh*cl) << 32).
  always_comb begin
    case (hstep_q)
      2'd0:    begin mul_a = key[31:0];            mul_b = GOLDEN_MULT[31:0];  end
      2'd1:    begin mul_a = key[31:0];            mul_b = GOLDEN_MULT[63:32]; end
      default: begin mul_a = 32'(key[KEY_W-1:32]); mul_b = GOLDEN_MULT[31:0];  end
    endcase
  end

  always_comb begin
    case (hstep_q)
      2'd0:    addend = '0;
      2'd1:    addend = prod;
      default: addend = {prod[31:0], 32'd0};
    endcase
  end

  // Home slot from the top bits, folded back when the table is not a power of two.
  always_comb begin
    home_wide = {1'b0, acc_q[63 -: IDX_W]};
    if (home_wide >= (IDX_W + 1)'(TABLE_ENTRIES)) begin
      home_wide = home_wide - (IDX_W + 1)'(TABLE_ENTRIES);
    end
  end

  assign miss_end = (probe_q == CNT_W'(TABLE_ENTRIES - 1));
  assign room = (CMP_W'(count_q) < CMP_W'(max_fill_q)) &&
                (count_q < CNT_W'(TABLE_ENTRIES));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_HASH;
      S_HASH:  if (hstep_q == 2'd3) state_d = S_HOME;
      S_HOME:  state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (rd_data.bitmap == '0 || rd_data.key == key || miss_end) begin
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    clr_d     = clr_q;
    hstep_d   = hstep_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    probe_d   = probe_q;
    cmd_d     = cmd_q;
    value_d   = value_q;
    found_d   = found_q;
    free_d    = free_q;
    count_d   = count_q;
    done_d    = 1'b0;
    present_d = present_q;
    status_d  = status_q;
    rd_en     = 1'b0;
    wr_req    = '0;
    unique case (state_q)
      S_CLEAR: begin
        wr_req.we   = 1'b1;
        wr_req.addr = clr_q;
        clr_d       = clr_q + IDX_W'(1);
      end
      S_IDLE: begin
        cmd_d   = command_i;
        value_d = value_i;
        hstep_d = 2'd0;
        acc_d   = '0;
      end
      S_HASH: begin
        acc_d   = acc_q + addend;
        hstep_d = hstep_q + 2'd1;
      end
      S_HOME: begin
        idx_d   = home_wide[IDX_W-1:0];
        probe_d = '0;
        found_d = 1'b0;
        free_d  = 1'b0;
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_CHECK: begin
        if (rd_data.bitmap == '0) begin
          free_d = 1'b1;
        end else if (rd_data.key == key) begin
          found_d = 1'b1;
        end else if (!miss_end) begin
          idx_d   = (idx_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_q + IDX_W'(1);
          probe_d = probe_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        done_d      = 1'b1;
        present_d   = found_q && ((rd_data.bitmap & bit_mask) != '0);
        status_d    = ST_OK;
        wr_req.addr = idx_q;
        wr_req.data.key = key;
        if (cmd_q == CMD_ADD) begin
          if (found_q) begin
            wr_req.we          = 1'b1;
            wr_req.data.bitmap = rd_data.bitmap | bit_mask;
          end else if (free_q && room) begin
            wr_req.we          = 1'b1;
            wr_req.data.bitmap = bit_mask;
            count_d            = count_q + CNT_W'(1);
          end else begin
            status_d = ST_FULL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      max_fill_q <= MAX_FILL_RESET;
      count_q    <= '0;
      clr_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        max_fill_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hstep_q   <= hstep_d;
    acc_q     <= acc_d;
    idx_q     <= idx_d;
    probe_q   <= probe_d;
    cmd_q     <= cmd_d;
    value_q   <= value_d;
    found_q   <= found_d;
    free_q    <= free_d;
    present_q <= present_d;
    status_q  <= status_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign present_o      = present_q;
  assign status_o       = status_q;
  assign bucket_count_o = COUNT_W'(count_q);

  // A result is only strobed once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while busy");

  // A rejected add never reports the value as present.
  a_full_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> !present_o)
    else $error("rejected add reported present");

  // An accepted transaction makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transaction accepted without going busy");

endmodule

>>> hdl/bbhs_mul.sv
// Shared 32x32 multiplier with a registered product, used for the partial products of the hash.
module bbhs_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;
  logic [63:0] prod_d;

  assign prod_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> hdl/bbhs_store.sv
// Bucket store: one write port and one registered read port.
module bbhs_store (
  input  logic                      clk_i,
  input  bbhs_pkg::wr_req_t         wr_i,
  input  logic                      rd_en_i,
  input  logic [bbhs_pkg::IDX_W-1:0] rd_addr_i,
  output bbhs_pkg::entry_t          rd_data_o
);
  import bbhs_pkg::*;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
